### src/assert_macros.svh
// Assertion macros shared by the filter RTL.
// Each macro expects i_clk and i_rst_n to be visible in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Checked only while the block is out of reset.
`define ACF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define ACF_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`endif

### src/acf_pkg.sv
// Shared types and constants of the ARGB convolution filter.
// No dependencies; the top level, the divider and the testbench import it.
package acf_pkg;

    localparam int unsigned MAX_KERNEL_DEF = 5;
    localparam int unsigned MAX_WIDTH_DEF  = 1024;
    localparam int unsigned MAX_HEIGHT_DEF = 4096;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int DEN_W      = 24;

    localparam logic [7:0]         CHAN_MAX = 8'hff;
    localparam logic signed [15:0] Q88_ONE  = 16'sd256;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 3'd0,
        CFG_IMAGE_HEIGHT = 3'd1,
        CFG_KERNEL_COLS  = 3'd2,
        CFG_KERNEL_ROWS  = 3'd3,
        CFG_DIVISOR      = 3'd4,
        CFG_BIAS         = 3'd5,
        CFG_EDGE_COLOR   = 3'd6,
        CFG_MODE_FLAGS   = 3'd7
    } t_cfg_idx;

    typedef enum logic [1:0] {
        CMD_COEFF = 2'd0,
        CMD_PIXEL = 2'd1,
        CMD_FLUSH = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PIX,
        S_CHK,
        S_TAP,
        S_ACC,
        S_NUM,
        S_DIV,
        S_OUT
    } t_state;

    typedef struct packed {
        logic            done;
        logic [3:0][7:0] q;
    } t_div_stat;

endpackage

### src/acf_in_if.sv
// Input channel of the filter: commands, coefficients and pixels.
// Valid/ready handshake; no dependencies.
interface acf_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         command;
    logic [4:0]         coeff_index;
    logic signed [15:0] coeff_value;
    logic [7:0]         pixel_blue;
    logic [7:0]         pixel_green;
    logic [7:0]         pixel_red;
    logic [7:0]         pixel_alpha;

    modport source (output valid, command, coeff_index, coeff_value, pixel_blue,
                    pixel_green, pixel_red, pixel_alpha, input ready);
    modport sink (input valid, command, coeff_index, coeff_value, pixel_blue,
                  pixel_green, pixel_red, pixel_alpha, output ready);
endinterface

### src/acf_out_if.sv
// Output channel of the filter: filtered pixels with their position.
// Valid/ready handshake; no dependencies.
interface acf_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_blue;
    logic [7:0]  out_green;
    logic [7:0]  out_red;
    logic [7:0]  out_alpha;
    logic [9:0]  out_x;
    logic [11:0] out_y;
    logic        frame_last;

    modport source (output valid, out_blue, out_green, out_red, out_alpha, out_x, out_y,
                    frame_last, input ready);
    modport sink (input valid, out_blue, out_green, out_red, out_alpha, out_x, out_y,
                  frame_last, output ready);
endinterface

### src/argb_convolution_filter_top.sv
// ARGB convolution filter, top level. A pixel is written to the line store and, when it
// releases a result, followed by one line-store read per kernel tap and an iterative
// division; a flush that releases a result runs the same tap reads and division. Items
// are handled one at a time. Synchronous active-low reset clears control, counters and
// coefficients; the line store is not cleared, so no clearing pass is run.
`include "assert_macros.svh"
module argb_convolution_filter_top
    import acf_pkg::*;
#(
    parameter int unsigned MAX_KERNEL = MAX_KERNEL_DEF,
    parameter int unsigned MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int unsigned MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    acf_in_if.sink                i_in,
    acf_out_if.source             o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Geometry derived from the size parameters.
    localparam int KW       = $clog2(MAX_KERNEL + 1);
    localparam int WW       = $clog2(MAX_WIDTH + 1);
    localparam int CW       = $clog2(MAX_WIDTH);
    localparam int HW       = $clog2(MAX_HEIGHT + 1);
    localparam int RW       = $clog2(MAX_HEIGHT);
    localparam int LS_DEPTH = MAX_KERNEL * MAX_WIDTH;
    localparam int AW       = $clog2(LS_DEPTH);
    localparam int CF_DEPTH = MAX_KERNEL * MAX_KERNEL;
    localparam int CFW      = (CF_DEPTH > 1) ? $clog2(CF_DEPTH) : 1;
    localparam int ACC_W    = 25 + $clog2(CF_DEPTH + 1);
    localparam int NUM_W    = ((ACC_W + 8 > 32) ? ACC_W + 8 : 32) + 1;
    localparam int LINW     = RW + WW + 2;
    localparam int SXW      = CW + 2;
    localparam int SYW      = RW + 2;
    localparam int OFFW     = AW + 2;

    // Configuration registers; the user must write them only while the block is idle, which the block does not enforce.
    logic [10:0]        r_img_w;
    logic [12:0]        r_img_h;
    logic [2:0]         r_kcols;
    logic [2:0]         r_krows;
    logic signed [15:0] r_div;
    logic signed [15:0] r_bias;
    logic [31:0]        r_edge;
    logic [1:0]         r_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w <= 11'd1;
            r_img_h <= 13'd1;
            r_kcols <= '0;
            r_krows <= '0;
            r_div   <= Q88_ONE;
            r_bias  <= '0;
            r_edge  <= '0;
            r_mode  <= 2'b11;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_IMAGE_WIDTH:  r_img_w <= i_cfg_data[10:0];
                CFG_IMAGE_HEIGHT: r_img_h <= i_cfg_data[12:0];
                CFG_KERNEL_COLS:  r_kcols <= i_cfg_data[2:0];
                CFG_KERNEL_ROWS:  r_krows <= i_cfg_data[2:0];
                CFG_DIVISOR:      r_div   <= i_cfg_data[15:0];
                CFG_BIAS:         r_bias  <= i_cfg_data[15:0];
                CFG_EDGE_COLOR:   r_edge  <= i_cfg_data;
                CFG_MODE_FLAGS:   r_mode  <= i_cfg_data[1:0];
                default:          r_mode  <= r_mode;
            endcase
        end
    end

    // Effective sizes: a zero width, height or divisor counts as one; oversize is limited to the build maximum.
    logic [WW-1:0]      w_eff;
    logic [HW-1:0]      h_eff;
    logic [KW-1:0]      kc;
    logic [KW-1:0]      kr;
    logic [KW-1:0]      half_c;
    logic [KW-1:0]      half_r;
    logic [KW-1:0]      da;
    logic [KW-1:0]      ra;
    logic signed [15:0] d_eff;

    always_comb begin
        if (r_img_w == '0) begin
            w_eff = WW'(1);
        end else if (32'(r_img_w) > MAX_WIDTH) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(r_img_w);
        end
        if (r_img_h == '0) begin
            h_eff = HW'(1);
        end else if (32'(r_img_h) > MAX_HEIGHT) begin
            h_eff = HW'(MAX_HEIGHT);
        end else begin
            h_eff = HW'(r_img_h);
        end
        kc     = (32'(r_kcols) > MAX_KERNEL) ? KW'(MAX_KERNEL) : KW'(r_kcols);
        kr     = (32'(r_krows) > MAX_KERNEL) ? KW'(MAX_KERNEL) : KW'(r_krows);
        half_c = kc >> 1;
        half_r = kr >> 1;
        // Lookahead in rows and columns that a result needs beyond its own pixel.
        da     = (kr == '0) ? '0 : kr - KW'(1) - half_r;
        ra     = (kc == '0) ? '0 : kc - KW'(1) - half_c;
        d_eff  = (r_div == '0) ? Q88_ONE : r_div;
    end

    // Sequencer state and handshake.
    t_state r_state;
    t_state n_state;
    logic   in_ready;
    logic   in_fire;
    logic   mem_we;
    logic   div_start;
    logic   issue;
    logic   out_load;
    logic   out_free;
    logic   emit_start;
    logic   emit_ok;
    logic   k_empty;
    logic   tap_last;
    t_cmd   cmd;

    // Stream position counters and their line-store addresses.
    logic [CW-1:0]   r_in_col;
    logic [RW-1:0]   r_in_row;
    logic [CW-1:0]   r_out_col;
    logic [RW-1:0]   r_out_row;
    logic [AW-1:0]   r_in_addr;
    logic [AW-1:0]   r_out_addr;
    logic            r_frame_done;
    logic [LINW-1:0] r_n_in;
    logic [LINW-1:0] r_lag;
    logic [LINW-1:0] m_lin;
    logic [31:0]     r_pix;

    // Tap walk.
    logic [KW-1:0]   r_kx;
    logic [KW-1:0]   r_ky;
    logic [CFW-1:0]  r_cidx;
    logic            r_centre;
    logic            r_p_valid;
    logic            r_p_centre;
    logic            r_p_edge;
    logic signed [15:0] r_p_coef;
    logic signed [15:0] r_coef [CF_DEPTH];

    // Line store.
    logic [31:0]     r_ls [LS_DEPTH];
    logic [31:0]     r_rd_data;
    logic [AW-1:0]   rd_addr;

    // Accumulation and output.
    logic signed [ACC_W-1:0] r_acc [4];
    logic [7:0]              r_alpha_c;
    logic [31:0]             tap_pix;
    logic signed [24:0]      prod [4];
    logic signed [31:0]      bd;
    logic [3:0][NUM_W-1:0]   div_num;
    logic signed [DEN_W-1:0] div_den;
    t_div_stat               div_stat;
    logic                    out_wrap;

    logic       r_ov;
    logic [7:0] r_o_blue;
    logic [7:0] r_o_green;
    logic [7:0] r_o_red;
    logic [7:0] r_o_alpha;
    logic [9:0] r_o_x;
    logic [11:0] r_o_y;
    logic       r_o_last;

    assign cmd      = t_cmd'(i_in.command);
    assign in_fire  = i_in.valid & in_ready;
    assign out_free = !r_ov || o_out.ready;
    assign k_empty  = (kc == '0) || (kr == '0);
    assign tap_last = (r_kx == kc - KW'(1)) && (r_ky == kr - KW'(1));

    // A result is due once the input has run DA rows and RA columns past its position.
    assign m_lin   = LINW'(r_out_row) * LINW'(w_eff) + LINW'(r_out_col);
    assign emit_ok = (m_lin + r_lag) <= r_n_in;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_fire && cmd == CMD_PIXEL) begin
                    n_state = S_PIX;
                end else if (in_fire && cmd == CMD_FLUSH && r_frame_done) begin
                    n_state = S_TAP;
                end
            end
            S_PIX: n_state = S_CHK;
            S_CHK: n_state = emit_ok ? S_TAP : S_IDLE;
            S_TAP: begin
                if (!r_centre && (k_empty || tap_last)) begin
                    n_state = S_ACC;
                end
            end
            S_ACC: n_state = S_NUM;
            S_NUM: n_state = S_DIV;
            S_DIV: begin
                if (div_stat.done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        in_ready   = 1'b0;
        mem_we     = 1'b0;
        div_start  = 1'b0;
        issue      = 1'b0;
        out_load   = 1'b0;
        emit_start = 1'b0;
        case (r_state)
            S_IDLE: begin
                in_ready   = 1'b1;
                emit_start = in_fire && cmd == CMD_FLUSH && r_frame_done;
            end
            S_PIX: mem_we = 1'b1;
            S_CHK: emit_start = emit_ok;
            S_TAP: issue = r_centre || !k_empty;
            S_NUM: div_start = 1'b1;
            S_OUT: out_load = out_free;
            default: in_ready = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Tap address: the clamped tap offset from the centre, added to the centre's store
    // address and folded once into the ring.
    logic signed [SXW-1:0]  sx, sx_cl, wx, dx, cx;
    logic signed [SYW-1:0]  sy, sy_cl, hy, dy, cy;
    logic signed [OFFW-1:0] off, tsum, ls_d;
    logic                   oob;
    logic                   tap_edge;

    always_comb begin
        cx = $signed(SXW'(r_out_col));
        cy = $signed(SYW'(r_out_row));
        wx = $signed(SXW'(w_eff));
        hy = $signed(SYW'(h_eff));
        sx = cx + $signed(SXW'(r_kx)) - $signed(SXW'(half_c));
        sy = cy + $signed(SYW'(r_ky)) - $signed(SYW'(half_r));
        oob = (sx < 0) || (sx >= wx) || (sy < 0) || (sy >= hy);
        if (sx < 0) begin
            sx_cl = '0;
        end else if (sx >= wx) begin
            sx_cl = wx - SXW'(1);
        end else begin
            sx_cl = sx;
        end
        if (sy < 0) begin
            sy_cl = '0;
        end else if (sy >= hy) begin
            sy_cl = hy - SYW'(1);
        end else begin
            sy_cl = sy;
        end
        dx       = sx_cl - cx;
        dy       = sy_cl - cy;
        tap_edge = oob && !r_mode[0];
        off      = OFFW'(dy) * $signed(OFFW'(w_eff)) + OFFW'(dx);
        tsum     = $signed(OFFW'(r_out_addr)) + off;
        ls_d     = $signed(OFFW'(LS_DEPTH));
        if (r_centre) begin
            rd_addr = r_out_addr;
        end else if (tsum < 0) begin
            rd_addr = AW'(tsum + ls_d);
        end else if (tsum >= ls_d) begin
            rd_addr = AW'(tsum - ls_d);
        end else begin
            rd_addr = AW'(tsum);
        end
    end

    // Line store: one write port for incoming pixels, one registered read port for taps.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_ls[r_in_addr] <= r_pix;
        end
        r_rd_data <= r_ls[rd_addr];
    end

    // Coefficient table.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CF_DEPTH; i++) begin
                r_coef[i] <= '0;
            end
        end else if (in_fire && cmd == CMD_COEFF && 32'(i_in.coeff_index) < CF_DEPTH) begin
            r_coef[CFW'(i_in.coeff_index)] <= i_in.coeff_value;
        end
    end

    // Stream counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col     <= '0;
            r_in_row     <= '0;
            r_out_col    <= '0;
            r_out_row    <= '0;
            r_in_addr    <= '0;
            r_out_addr   <= '0;
            r_frame_done <= 1'b0;
        end else begin
            // A pixel after a finished frame opens a new one; undrained results are dropped.
            if (in_fire && cmd == CMD_PIXEL && r_frame_done) begin
                r_in_col     <= '0;
                r_in_row     <= '0;
                r_out_col    <= '0;
                r_out_row    <= '0;
                r_in_addr    <= '0;
                r_out_addr   <= '0;
                r_frame_done <= 1'b0;
            end
            if (mem_we) begin
                r_in_addr <= (32'(r_in_addr) == LS_DEPTH - 1) ? '0 : r_in_addr + AW'(1);
                if ((WW+1)'(r_in_col) + (WW+1)'(1) >= (WW+1)'(w_eff)) begin
                    r_in_col <= '0;
                    if ((HW+1)'(r_in_row) + (HW+1)'(1) >= (HW+1)'(h_eff)) begin
                        r_in_row     <= '0;
                        r_frame_done <= 1'b1;
                    end else begin
                        r_in_row <= r_in_row + RW'(1);
                    end
                end else begin
                    r_in_col <= r_in_col + CW'(1);
                end
            end
            if (out_load) begin
                r_out_addr <= (32'(r_out_addr) == LS_DEPTH - 1) ? '0 : r_out_addr + AW'(1);
                if ((WW+1)'(r_out_col) + (WW+1)'(1) >= (WW+1)'(w_eff)) begin
                    r_out_col <= '0;
                    if (out_wrap) begin
                        r_out_row    <= '0;
                        r_frame_done <= 1'b0;
                    end else begin
                        r_out_row <= r_out_row + RW'(1);
                    end
                end else begin
                    r_out_col <= r_out_col + CW'(1);
                end
            end
        end
    end

    assign out_wrap = ((WW+1)'(r_out_col) + (WW+1)'(1) >= (WW+1)'(w_eff)) &&
                      ((HW+1)'(r_out_row) + (HW+1)'(1) >= (HW+1)'(h_eff));

    // Pixel capture and the linear positions used by the release test.
    always_ff @(posedge i_clk) begin
        if (in_fire && cmd == CMD_PIXEL) begin
            r_pix <= {i_in.pixel_alpha, i_in.pixel_red, i_in.pixel_green, i_in.pixel_blue};
        end
        if (mem_we) begin
            r_n_in <= LINW'(r_in_row) * LINW'(w_eff) + LINW'(r_in_col);
            r_lag  <= LINW'(da) * LINW'(w_eff) + LINW'(ra);
        end
    end

    // Tap walk: the centre is read first for preserved alpha, then taps in row-major order.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_centre  <= 1'b0;
            r_kx      <= '0;
            r_ky      <= '0;
            r_cidx    <= '0;
        end else begin
            r_p_valid <= issue;
            if (emit_start) begin
                r_centre <= 1'b1;
                r_kx     <= '0;
                r_ky     <= '0;
                r_cidx   <= '0;
            end else if (issue) begin
                if (r_centre) begin
                    r_centre <= 1'b0;
                end else begin
                    r_cidx <= r_cidx + CFW'(1);
                    if (r_kx == kc - KW'(1)) begin
                        r_kx <= '0;
                        r_ky <= r_ky + KW'(1);
                    end else begin
                        r_kx <= r_kx + KW'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_p_centre <= r_centre;
            r_p_edge   <= !r_centre && tap_edge;
            r_p_coef   <= r_coef[r_cidx];
        end
    end

    // Multiply-accumulate of one tap per cycle on all four channels.
    always_comb begin
        tap_pix = r_p_edge ? r_edge : r_rd_data;
        for (int ch = 0; ch < 4; ch++) begin
            prod[ch] = $signed({1'b0, tap_pix[8*ch +: 8]}) * r_p_coef;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_start) begin
            for (int ch = 0; ch < 4; ch++) begin
                r_acc[ch] <= '0;
            end
        end else if (r_p_valid) begin
            if (r_p_centre) begin
                r_alpha_c <= tap_pix[31:24];
            end else begin
                for (int ch = 0; ch < 4; ch++) begin
                    r_acc[ch] <= r_acc[ch] + ACC_W'(prod[ch]);
                end
            end
        end
    end

    // Channel result: (256*S + B*D) / (256*D), truncated toward zero, limited to 0..255.
    always_comb begin
        bd      = r_bias * d_eff;
        div_den = {d_eff, 8'h00};
        for (int ch = 0; ch < 4; ch++) begin
            div_num[ch] = (NUM_W'(r_acc[ch]) << 8) + NUM_W'(bd);
        end
    end

    acf_quot #(
        .NUM_W (NUM_W)
    ) u_quot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_stat  (div_stat)
    );

    // Output register: the input side stays open while a result waits here.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (out_load) begin
            r_ov <= 1'b1;
        end else if (o_out.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_blue  <= div_stat.q[0];
            r_o_green <= div_stat.q[1];
            r_o_red   <= div_stat.q[2];
            r_o_alpha <= r_mode[1] ? r_alpha_c : div_stat.q[3];
            r_o_x     <= 10'(r_out_col);
            r_o_y     <= 12'(r_out_row);
            r_o_last  <= out_wrap;
        end
    end

    assign i_in.ready       = in_ready;
    assign o_out.valid      = r_ov;
    assign o_out.out_blue   = r_o_blue;
    assign o_out.out_green  = r_o_green;
    assign o_out.out_red    = r_o_red;
    assign o_out.out_alpha  = r_o_alpha;
    assign o_out.out_x      = r_o_x;
    assign o_out.out_y      = r_o_y;
    assign o_out.frame_last = r_o_last;

    `ACF_ASSERT_RST(a_reset_to_idle, !i_rst_n |=> r_state == S_IDLE, "reset must idle the sequencer")
    `ACF_ASSERT(a_div_done_in_wait, div_stat.done |-> r_state == S_DIV, "divider done outside wait")
    `ACF_ASSERT(a_store_write_source, mem_we |-> $past(in_fire && cmd == CMD_PIXEL), "stray store write")
    `ACF_ASSERT(a_frame_end_rewinds, (out_load && out_wrap) |=> (r_out_col == '0 && r_out_row == '0 && !r_frame_done), "frame end did not rewind")

endmodule

### src/acf_quot.sv
// Iterative four-lane divider producing saturated 0..255 quotients.
// Depends on acf_pkg.
module acf_quot
    import acf_pkg::*;
#(
    parameter int NUM_W = 38
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [3:0][NUM_W-1:0]       i_num,
    input  logic signed [DEN_W-1:0]     i_den,
    output t_div_stat                   o_stat
);

    logic [3:0]                  r_cnt;
    logic                        r_done;
    logic [3:0][NUM_W-1:0]       r_rem;
    logic [DEN_W-1:0]            r_dmag;
    logic [3:0]                  r_neg;
    logic [3:0]                  r_sat;
    logic [3:0][7:0]             r_q;
    logic [3:0]                  shamt;
    logic [NUM_W-1:0]            dsh;

    // The first step after start only checks for saturation; then eight quotient bits.
    always_comb begin
        shamt = (r_cnt == 4'd9) ? 4'd8 : r_cnt - 4'd1;
        dsh   = NUM_W'(r_dmag) << shamt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == 4'd1);
            if (i_start) begin
                r_cnt <= 4'd9;
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dmag <= i_den[DEN_W-1] ? DEN_W'(-i_den) : DEN_W'(i_den);
            for (int l = 0; l < 4; l++) begin
                r_rem[l] <= i_num[l][NUM_W-1] ? (~i_num[l] + NUM_W'(1)) : i_num[l];
                r_neg[l] <= (i_num[l][NUM_W-1] ^ i_den[DEN_W-1]) && (i_num[l] != '0);
                r_q[l]   <= '0;
                r_sat[l] <= 1'b0;
            end
        end else if (r_cnt == 4'd9) begin
            for (int l = 0; l < 4; l++) begin
                r_sat[l] <= (r_rem[l] >= dsh);
            end
        end else if (r_cnt != '0) begin
            for (int l = 0; l < 4; l++) begin
                if (r_rem[l] >= dsh) begin
                    r_rem[l]            <= r_rem[l] - dsh;
                    r_q[l][shamt[2:0]]  <= 1'b1;
                end
            end
        end
    end

    always_comb begin
        o_stat.done = r_done;
        for (int l = 0; l < 4; l++) begin
            if (r_neg[l]) begin
                o_stat.q[l] = '0;
            end else if (r_sat[l]) begin
                o_stat.q[l] = CHAN_MAX;
            end else begin
                o_stat.q[l] = r_q[l];
            end
        end
    end

endmodule

### tb/testbench.sv
// Self-checking testbench for the ARGB convolution filter top level.
// Depends on acf_pkg, acf_in_if, acf_out_if and the filter top level. It predicts every filtered pixel
// from its own model of the filter and checks the block's output stream against it.
`timescale 1ns / 1ps

module testbench;
    import acf_pkg::*;

    localparam int unsigned STORE_DEPTH = MAX_KERNEL_DEF * MAX_WIDTH_DEF;
    localparam int unsigned COEF_DEPTH  = MAX_KERNEL_DEF * MAX_KERNEL_DEF;
    localparam int unsigned ITEM_TARGET = 950;
    localparam int unsigned QUIET_AFTER = 800;   // no idling once this many items went in
    localparam int unsigned SETTLE      = 60;    // cycles a silent item may still be working
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned LONG_HOLD   = 400;

    // One filtered pixel as the output channel presents it.
    typedef struct packed {
        logic [7:0]  blue;
        logic [7:0]  green;
        logic [7:0]  red;
        logic [7:0]  alpha;
        logic [9:0]  x;
        logic [11:0] y;
        logic        last;
    } t_filtered;

    // The scoreboard keeps its own copy of the filter state and configuration. Each
    // accepted input item is run through it, and any pixel it releases is queued.
    class filter_scoreboard;
        logic [31:0] line_px [STORE_DEPTH];
        logic [15:0] kernel [COEF_DEPTH];
        int unsigned in_col, in_row, out_col, out_row;
        bit          frame_done;
        logic [10:0] reg_width;
        logic [12:0] reg_height;
        logic [2:0]  reg_cols, reg_rows;
        logic [15:0] reg_div, reg_bias;
        logic [31:0] reg_edge;
        logic [1:0]  reg_mode;
        t_filtered   pending[$];
        int          errors;

        function new();
            foreach (line_px[i]) line_px[i] = '0;
            foreach (kernel[i]) kernel[i] = '0;
            in_col = 0; in_row = 0; out_col = 0; out_row = 0;
            frame_done = 0;
            reg_width = 1; reg_height = 1; reg_cols = 0; reg_rows = 0;
            reg_div = 16'd256; reg_bias = 0; reg_edge = 0; reg_mode = 2'd3;
            errors = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [31:0] d);
            case (idx)
                CFG_IMAGE_WIDTH:  reg_width  = d[10:0];
                CFG_IMAGE_HEIGHT: reg_height = d[12:0];
                CFG_KERNEL_COLS:  reg_cols   = d[2:0];
                CFG_KERNEL_ROWS:  reg_rows   = d[2:0];
                CFG_DIVISOR:      reg_div    = d[15:0];
                CFG_BIAS:         reg_bias   = d[15:0];
                CFG_EDGE_COLOR:   reg_edge   = d;
                CFG_MODE_FLAGS:   reg_mode   = d[1:0];
                default: ;
            endcase
        endfunction

        function int unsigned width_used();
            if (reg_width == 0) return 1;
            if (reg_width > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
            return reg_width;
        endfunction

        function int unsigned height_used();
            if (reg_height == 0) return 1;
            if (reg_height > MAX_HEIGHT_DEF) return MAX_HEIGHT_DEF;
            return reg_height;
        endfunction

        function int unsigned kernel_dim(logic [2:0] v);
            return (v > MAX_KERNEL_DEF) ? MAX_KERNEL_DEF : v;
        endfunction

        // Off-image taps take either the nearest edge pixel or the edge color.
        function logic [31:0] tap(longint sx, longint sy, int unsigned w, int unsigned h);
            if (sx < 0 || sy < 0 || sx >= longint'(w) || sy >= longint'(h)) begin
                if (!reg_mode[0]) return reg_edge;
                if (sx < 0) sx = 0;
                if (sx >= longint'(w)) sx = longint'(w) - 1;
                if (sy < 0) sy = 0;
                if (sy >= longint'(h)) sy = longint'(h) - 1;
            end
            return line_px[(sy * longint'(w) + sx) % STORE_DEPTH];
        endfunction

        // Divide by the Q8.8 divisor, add the Q8.8 bias, truncate and saturate.
        function logic [7:0] scale(longint acc, longint d, longint b);
            longint num, den, q;
            num = acc * 256 + b * d;
            den = 256 * d;
            if (den < 0) begin
                num = -num;
                den = -den;
            end
            q = num / den;
            if (q < 0) q = 0;
            if (q > 255) q = 255;
            return q[7:0];
        endfunction

        function t_filtered filter_next();
            int unsigned w, h, c, r;
            longint      acc [4];
            longint      d, b, cf;
            logic [31:0] p;
            t_filtered   res;
            w = width_used();
            h = height_used();
            c = kernel_dim(reg_cols);
            r = kernel_dim(reg_rows);
            d = longint'($signed(reg_div));
            b = longint'($signed(reg_bias));
            if (d == 0) d = 256;
            foreach (acc[i]) acc[i] = 0;
            for (int ky = 0; ky < r; ky++) begin
                for (int kx = 0; kx < c; kx++) begin
                    p = tap(longint'(out_col) + kx - longint'(c / 2),
                            longint'(out_row) + ky - longint'(r / 2), w, h);
                    cf = longint'($signed(kernel[(ky * c + kx) % COEF_DEPTH]));
                    for (int ch = 0; ch < 4; ch++)
                        acc[ch] += longint'(p[8*ch +: 8]) * cf;
                end
            end
            res.blue  = scale(acc[0], d, b);
            res.green = scale(acc[1], d, b);
            res.red   = scale(acc[2], d, b);
            res.alpha = scale(acc[3], d, b);
            if (reg_mode[1]) begin
                p = tap(out_col, out_row, w, h);
                res.alpha = p[31:24];
            end
            res.x = out_col[9:0];
            res.y = out_row[11:0];
            res.last = 0;
            out_col++;
            if (out_col >= w) begin
                out_col = 0;
                out_row++;
                if (out_row >= h) begin
                    out_row = 0;
                    res.last = 1;
                    frame_done = 0;
                end
            end
            return res;
        endfunction

        function void note_input(t_cmd cmd, logic [4:0] idx, logic [15:0] val,
                                 logic [31:0] pix);
            int unsigned w, h, c, r, lag_rows, lag_cols, n_in, m;
            case (cmd)
                CMD_COEFF: if (idx < COEF_DEPTH) kernel[idx] = val;
                CMD_PIXEL: begin
                    w = width_used();
                    h = height_used();
                    c = kernel_dim(reg_cols);
                    r = kernel_dim(reg_rows);
                    lag_rows = (r != 0) ? r - 1 - r / 2 : 0;
                    lag_cols = (c != 0) ? c - 1 - c / 2 : 0;
                    // A pixel after a complete frame starts a new one; undrained
                    // outputs of the old frame are dropped.
                    if (frame_done) begin
                        frame_done = 0;
                        in_col = 0; in_row = 0; out_col = 0; out_row = 0;
                    end
                    n_in = in_row * w + in_col;
                    line_px[n_in % STORE_DEPTH] = pix;
                    in_col++;
                    if (in_col >= w) begin
                        in_col = 0;
                        in_row++;
                        if (in_row >= h) begin
                            in_row = 0;
                            frame_done = 1;
                        end
                    end
                    m = out_row * w + out_col;
                    if (m + lag_rows * w + lag_cols <= n_in) pending.push_back(filter_next());
                end
                CMD_FLUSH: if (frame_done) pending.push_back(filter_next());
                default: ;
            endcase
        endfunction

        task report(string what);
            $display("[%0t] mismatch: %s", $realtime, what);
            errors++;
        endtask

        task check_result(t_filtered got);
            t_filtered e;
            if (pending.size() == 0) begin
                report($sformatf("unexpected pixel x=%0d y=%0d", got.x, got.y));
                return;
            end
            e = pending.pop_front();
            if (got.blue !== e.blue)
                report($sformatf("blue %0d, want %0d", got.blue, e.blue));
            if (got.green !== e.green)
                report($sformatf("green %0d, want %0d", got.green, e.green));
            if (got.red !== e.red)
                report($sformatf("red %0d, want %0d", got.red, e.red));
            if (got.alpha !== e.alpha)
                report($sformatf("alpha %0d, want %0d", got.alpha, e.alpha));
            if (got.x !== e.x)
                report($sformatf("x %0d, want %0d", got.x, e.x));
            if (got.y !== e.y)
                report($sformatf("y %0d, want %0d", got.y, e.y));
            if (got.last !== e.last)
                report($sformatf("frame_last %0b, want %0b", got.last, e.last));
        endtask
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    acf_in_if  pix_in ();
    acf_out_if pix_out ();

    argb_convolution_filter_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (pix_in),
        .o_out      (pix_out),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    filter_scoreboard sb;
    int unsigned      items_sent;
    int unsigned      cycles;
    bit               idling_on;
    bit               hold_request;   // asks the receiver for one long hold-off
    int unsigned      hold_left;
    int unsigned      stall_left;

    // 2 ns clock.
    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // The run is bounded; a hung handshake ends here.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("testbench failed");
            $finish;
        end
    end

    // Receiver: checks every output transfer and drives ready. Stalls come in random
    // bursts; a long hold-off, when asked for, is counted here so that the block backs
    // up into its input while the sender keeps offering items.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (pix_out.valid && pix_out.ready)
                sb.check_result({pix_out.out_blue, pix_out.out_green, pix_out.out_red,
                                 pix_out.out_alpha, pix_out.out_x, pix_out.out_y,
                                 pix_out.frame_last});
            if (hold_request) begin
                hold_request = 0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                pix_out.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                pix_out.ready <= 1'b0;
            end else if (idling_on && $urandom_range(0, 3) == 0) begin
                stall_left = $urandom_range(1, 8) - 1;
                pix_out.ready <= 1'b0;
            end else begin
                pix_out.ready <= 1'b1;
            end
        end
    end

    // Offer one item and hold it until the block takes it. Valid stays high between
    // back-to-back items, so it gets only one assignment per step.
    task send(t_cmd cmd, logic [4:0] idx, logic [15:0] val, logic [31:0] pix);
        int unsigned gap;
        gap = (idling_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
        if (gap > 0) begin
            pix_in.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pix_in.valid       <= 1'b1;
        pix_in.command     <= cmd;
        pix_in.coeff_index <= idx;
        pix_in.coeff_value <= val;
        pix_in.pixel_blue  <= pix[7:0];
        pix_in.pixel_green <= pix[15:8];
        pix_in.pixel_red   <= pix[23:16];
        pix_in.pixel_alpha <= pix[31:24];
        do @(posedge i_clk); while (!pix_in.ready);
        sb.note_input(cmd, idx, val, pix);
        items_sent++;
        if (items_sent >= QUIET_AFTER) idling_on = 0;
    endtask

    // Registers change only while the block is idle: every expected pixel has come out
    // and any silent item in flight has had time to finish.
    task wait_idle();
        pix_in.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task write_reg(t_cfg_idx idx, logic [31:0] d);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= d;
        @(posedge i_clk);
        sb.set_reg(idx, d);
    endtask

    task configure(logic [31:0] w, logic [31:0] h, logic [31:0] kc, logic [31:0] kr,
                   logic [31:0] dv, logic [31:0] bs, logic [31:0] ec, logic [31:0] md);
        write_reg(CFG_IMAGE_WIDTH, w);
        write_reg(CFG_IMAGE_HEIGHT, h);
        write_reg(CFG_KERNEL_COLS, kc);
        write_reg(CFG_KERNEL_ROWS, kr);
        write_reg(CFG_DIVISOR, dv);
        write_reg(CFG_BIAS, bs);
        write_reg(CFG_EDGE_COLOR, ec);
        write_reg(CFG_MODE_FLAGS, md);
        cfg_we <= 1'b0;
    endtask

    // Coefficients lean toward small magnitudes so that sums do not always saturate.
    function logic [15:0] random_coef();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7fff;
            2, 3: return $urandom;
            default: return 16'($urandom_range(0, 1024) - 512);
        endcase
    endfunction

    function logic [31:0] random_pixel();
        case ($urandom_range(0, 9))
            0: return 32'h0;
            1: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    function logic [15:0] random_q88();
        case ($urandom_range(0, 7))
            0: return 16'h0;
            1: return 16'h8000;
            2: return 16'h7fff;
            3: return 16'hffff;
            4: return 16'd1;
            5: return 16'd256;
            default: return $urandom;
        endcase
    endfunction

    // Items that land between pixels: coefficient writes (some out of range), flushes
    // before the frame is complete, and the unused command.
    task send_noise();
        case ($urandom_range(0, 3))
            0, 1: send(CMD_COEFF, 5'($urandom_range(0, 31)), random_coef(), $urandom);
            2: send(CMD_FLUSH, $urandom, $urandom, $urandom);
            default: send(CMD_NONE, $urandom, $urandom, $urandom);
        endcase
    endtask

    // One frame of pixels. Unless asked to leave it undrained, flushes follow until
    // every output of the frame has been released.
    task send_frame(bit drain);
        int unsigned npix;
        npix = sb.width_used() * sb.height_used();
        for (int unsigned i = 0; i < npix; i++) begin
            if ($urandom_range(0, 7) == 0) send_noise();
            send(CMD_PIXEL, $urandom, $urandom, random_pixel());
        end
        while (drain && sb.frame_done) send(CMD_FLUSH, $urandom, $urandom, $urandom);
    endtask

    initial begin
        int unsigned phase, frames;
        sb = new();
        i_rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = '0;
        cfg_data = '0;
        pix_in.valid = 1'b0;
        pix_in.command = CMD_NONE;
        pix_in.coeff_index = '0;
        pix_in.coeff_value = '0;
        pix_in.pixel_blue = '0;
        pix_in.pixel_green = '0;
        pix_in.pixel_red = '0;
        pix_in.pixel_alpha = '0;
        pix_out.ready = 1'b0;
        items_sent = 0;
        cycles = 0;
        idling_on = 1;
        hold_request = 0;
        hold_left = 0;
        stall_left = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: a 2x2 image under a 3x3 kernel with clamped edges and a zero
        // divisor, coefficient extremes, an out-of-range index, the unused command, a
        // flush with nothing pending, pixels at both ends of the range, then the drain
        // and one flush too many.
        configure(2, 2, 3, 3, 0, 0, 32'h8040_2010, 1);
        send(CMD_COEFF, 0, 16'h8000, 0);
        send(CMD_COEFF, 4, 16'h7fff, 0);
        send(CMD_COEFF, 8, 16'd256, 0);
        send(CMD_COEFF, 24, 16'd256, 0);
        send(CMD_COEFF, 31, 16'd100, 0);
        send(CMD_NONE, 5'h1f, 16'hffff, 32'hffff_ffff);
        send(CMD_FLUSH, 0, 0, 0);
        send(CMD_PIXEL, 0, 0, 32'h0000_0000);
        send(CMD_PIXEL, 0, 0, 32'hffff_ffff);
        send(CMD_PIXEL, 0, 0, 32'h55aa_55aa);
        send(CMD_PIXEL, 0, 0, 32'haa55_aa55);
        while (sb.frame_done) send(CMD_FLUSH, 0, 0, 0);
        send(CMD_FLUSH, 0, 0, 0);

        // Random phases: a fresh setting of every register, a few coefficients, then
        // one to three frames. Now and then a frame is left undrained so that the next
        // pixel starts a new frame over it.
        phase = 0;
        while (items_sent < ITEM_TARGET - 40) begin
            wait_idle();
            configure($urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 8),
                      $urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 6),
                      $urandom_range(0, 7), $urandom_range(0, 7),
                      random_q88(), random_q88(), $urandom, $urandom_range(0, 3));
            repeat ($urandom_range(2, 10))
                send(CMD_COEFF, 5'($urandom_range(0, 26)), random_coef(), $urandom);
            // Early on, the receiver holds off for a long stretch while pixels keep coming.
            if (phase == 2) hold_request = 1;
            frames = $urandom_range(1, 3);
            for (int unsigned f = 0; f < frames; f++)
                send_frame(f == frames - 1 || $urandom_range(0, 7) != 0);
            phase++;
        end

        // Largest sizes, written with values past their limits: the first pixels of a
        // full-size frame, which release nothing yet under a 5x5 kernel.
        wait_idle();
        configure(32'h7ff, 32'h1fff, 7, 6, 32'h8000, 32'h7fff, 32'hffff_ffff, 0);
        repeat (40) send(CMD_PIXEL, $urandom, $urandom, random_pixel());

        wait_idle();
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule

### argb_convolution_filter_top.f
+incdir+src
src/acf_pkg.sv
src/acf_in_if.sv
src/acf_out_if.sv
src/acf_quot.sv
src/argb_convolution_filter_top.sv
tb/testbench.sv
